// ===== sv/sstk_pkg.sv =====
package sstk_pkg;

   localparam int DOT_W   = 44;
   localparam int SUM_W   = 28;
   localparam int WGT_W   = 16;
   localparam int IDX_W   = 16;
   localparam int SCORE_W = 17;
   localparam int DEN_W   = 2 * SUM_W;
   localparam int REM_W   = DEN_W + 1;
   localparam int HALF_W  = SUM_W / 2;

   localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(65536);

   // One finished candidate handed from the accumulator to the scorer.
   typedef struct packed {
      logic [DOT_W-1:0] dot;
      logic [SUM_W-1:0] query_sum;
      logic [SUM_W-1:0] candidate_sum;
      logic [IDX_W-1:0] index;
      logic             last_candidate;
   } job_type;

endpackage

// ===== sv/sstk_req_if.sv =====
interface sstk_req_if import sstk_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WGT_W-1:0] query_weight;
   logic [WGT_W-1:0] candidate_weight;
   logic [IDX_W-1:0] candidate_index;
   logic             last_element;
   logic             last_candidate;

   modport source (output valid, query_weight, candidate_weight, candidate_index,
                   last_element, last_candidate, input ready);
   modport sink   (input valid, query_weight, candidate_weight, candidate_index,
                   last_element, last_candidate, output ready);
endinterface

// ===== sv/sstk_rsp_if.sv =====
interface sstk_rsp_if import sstk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   neighbor_index;
   logic [SCORE_W-1:0] neighbor_score;
   logic               last_result;

   modport source (output valid, neighbor_index, neighbor_score, last_result,
                   input ready);
   modport sink   (input valid, neighbor_index, neighbor_score, last_result,
                   output ready);
endinterface

// ===== sv/sstk_queue.sv =====
module sstk_queue import sstk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type     slot_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ff, rd_in;
   logic        wr_ff, wr_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      if (push && !full) begin
         wr_in = ~wr_ff;
      end
      if (pop && not_empty) begin
         rd_in = ~rd_ff;
      end
      if ((push && !full) && !(pop && not_empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && not_empty)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push && !full) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/sstk_front.sv =====
module sstk_front import sstk_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   sstk_req_if.sink req,
   output logic     push,
   output job_type  push_data,
   input  logic     queue_full
);

   logic [DOT_W-1:0] dot_ff, dot_in;
   logic [SUM_W-1:0] qsum_ff, qsum_in;
   logic [SUM_W-1:0] csum_ff, csum_in;
   logic [DOT_W-1:0] dot_sum;
   logic [SUM_W-1:0] qsum_sum;
   logic [SUM_W-1:0] csum_sum;
   logic             take;

   assign req.ready = !queue_full;
   assign take      = req.valid && !queue_full;

   assign dot_sum  = dot_ff + DOT_W'(req.query_weight * req.candidate_weight);
   assign qsum_sum = qsum_ff + SUM_W'(req.query_weight);
   assign csum_sum = csum_ff + SUM_W'(req.candidate_weight);

   assign push                     = take && req.last_element;
   assign push_data.dot            = dot_sum;
   assign push_data.query_sum      = qsum_sum;
   assign push_data.candidate_sum  = csum_sum;
   assign push_data.index          = req.candidate_index;
   assign push_data.last_candidate = req.last_candidate;

   always_comb begin
      dot_in  = dot_ff;
      qsum_in = qsum_ff;
      csum_in = csum_ff;
      if (take) begin
         if (req.last_element) begin
            dot_in  = '0;
            qsum_in = '0;
            csum_in = '0;
         end else begin
            dot_in  = dot_sum;
            qsum_in = qsum_sum;
            csum_in = csum_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         qsum_ff <= '0;
         csum_ff <= '0;
      end else begin
         dot_ff  <= dot_in;
         qsum_ff <= qsum_in;
         csum_ff <= csum_in;
      end
   end

endmodule

// ===== sv/sstk_back.sv =====
module sstk_back import sstk_pkg::*; #(
   parameter int TOP_K = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   sstk_rsp_if.source rsp
);

   localparam int FILL_W = $clog2(TOP_K + 1);
   localparam logic [FILL_W-1:0] FULL = FILL_W'(TOP_K);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_LO = 3'd1;
   localparam logic [2:0] ST_MUL_HI = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_INSERT = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]         state_ff, state_in;
   job_type            job_ff;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SCORE_W-1:0] quot_ff, quot_in;
   logic [4:0]         step_ff, step_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   logic [IDX_W-1:0]   cell_idx_ff   [TOP_K];
   logic [SCORE_W-1:0] cell_score_ff [TOP_K];
   logic [IDX_W-1:0]   cell_idx_in   [TOP_K];
   logic [SCORE_W-1:0] cell_score_in [TOP_K];
   logic [TOP_K-1:0]   le;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_last_ff;
   logic               emit_load;

   logic [REM_W-1:0]   diff;
   logic               ge;
   logic [REM_W-1:0]   r_next;
   logic               full;
   logic               do_insert;
   logic               do_replace;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.neighbor_index = rsp_idx_ff;
   assign rsp.neighbor_score = rsp_score_ff;
   assign rsp.last_result    = rsp_last_ff;

   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   assign ge     = rem_ff >= REM_W'(den_ff);
   assign diff   = rem_ff - REM_W'(den_ff);
   assign r_next = ge ? diff : rem_ff;

   assign full       = (fill_ff == FULL);
   assign do_insert  = (state_ff == ST_INSERT) && !full;
   assign do_replace = (state_ff == ST_INSERT) && full && (score_ff > cell_score_ff[0]);

   // Entries kept sorted ascending; le marks the prefix not above the new score.
   always_comb begin
      for (int i = 0; i < TOP_K; i++) begin
         le[i] = (FILL_W'(i) < fill_ff) && (cell_score_ff[i] <= score_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < TOP_K; i++) begin
         cell_idx_in[i]   = cell_idx_ff[i];
         cell_score_in[i] = cell_score_ff[i];
         if (do_insert) begin
            if (!le[i]) begin
               if (i == 0) begin
                  cell_idx_in[i]   = job_ff.index;
                  cell_score_in[i] = score_ff;
               end else if (le[(i == 0) ? 0 : i-1]) begin
                  cell_idx_in[i]   = job_ff.index;
                  cell_score_in[i] = score_ff;
               end else begin
                  cell_idx_in[i]   = cell_idx_ff[(i == 0) ? 0 : i-1];
                  cell_score_in[i] = cell_score_ff[(i == 0) ? 0 : i-1];
               end
            end
         end else if (do_replace) begin
            // Drop the minimum, slide the lower part down, place the new entry.
            if ((i < TOP_K-1) && le[(i < TOP_K-1) ? i+1 : i]) begin
               cell_idx_in[i]   = cell_idx_ff[(i < TOP_K-1) ? i+1 : i];
               cell_score_in[i] = cell_score_ff[(i < TOP_K-1) ? i+1 : i];
            end else if (le[i]) begin
               cell_idx_in[i]   = job_ff.index;
               cell_score_in[i] = score_ff;
            end
         end else if (emit_load) begin
            if (i < TOP_K-1) begin
               cell_idx_in[i]   = cell_idx_ff[(i < TOP_K-1) ? i+1 : i];
               cell_score_in[i] = cell_score_ff[(i < TOP_K-1) ? i+1 : i];
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      score_in     = score_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if ((job.query_sum == '0) || (job.candidate_sum == '0)) begin
                  score_in = '0;
                  state_in = ST_INSERT;
               end else begin
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: begin
            den_in   = DEN_W'(job_ff.query_sum * job_ff.candidate_sum[HALF_W-1:0]);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            den_in = den_ff +
                     (DEN_W'(job_ff.query_sum * job_ff.candidate_sum[SUM_W-1:HALF_W])
                      << HALF_W);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // A quotient of 2^17 or more saturates at once.
            if (REM_W'(job_ff.dot) >= {den_ff, 1'b0}) begin
               score_in = SCORE_ONE;
               state_in = ST_INSERT;
            end else begin
               rem_in   = REM_W'(job_ff.dot);
               quot_in  = '0;
               step_in  = 5'(SCORE_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = {quot_ff[SCORE_W-2:0], ge};
            rem_in  = r_next << 1;
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               score_in = ({quot_ff[SCORE_W-2:0], ge} > SCORE_ONE) ? SCORE_ONE
                          : {quot_ff[SCORE_W-2:0], ge};
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (do_insert) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            state_in = job_ff.last_candidate ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               fill_in      = fill_ff - FILL_W'(1);
               if (fill_ff == FILL_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (job_pop) begin
         job_ff <= job;
      end
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      score_ff <= score_in;
      for (int i = 0; i < TOP_K; i++) begin
         cell_idx_ff[i]   <= cell_idx_in[i];
         cell_score_ff[i] <= cell_score_in[i];
      end
      if (emit_load) begin
         rsp_idx_ff   <= cell_idx_ff[0];
         rsp_score_ff <= cell_score_ff[0];
         rsp_last_ff  <= (fill_ff == FILL_W'(1));
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("kept count above capacity");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (fill_ff != '0))
      else $error("emitting from an empty set");

   a_div_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("divide by zero denominator");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (emit_load && (fill_ff == FILL_W'(1))) |=> (state_ff == ST_IDLE))
      else $error("emission did not finish on last neighbor");

endmodule

// ===== sv/similarity_top_k_selector.sv =====
// Nearest-neighbor selector over a stream of candidate vectors.
// req: one beat per vector element (query weight, candidate weight, index,
//   last_element, last_candidate). Elements accumulate at one beat per cycle
//   while the two-entry candidate queue has room.
// At last_element the candidate moves to the scorer: a pop, a low and a high
//   multiply, a range check and 17 divide steps, then an insert into the
//   TOP_K sorted cells; a saturating range check skips the divide, and a zero
//   sum goes from the pop straight to the insert.
//   Element beats of the next vector keep flowing meanwhile; the queue fills
//   when vectors are shorter than the scoring time or during emission.
// rsp: at the last candidate the kept neighbors leave in ascending score
//   order, equal scores in arrival order, one beat per cycle from a single
//   output register; last_result marks the final one. A stalled receiver
//   holds the register and freezes emission; the scorer waits behind it.
// Reset (synchronous, active high) clears the accumulators, the queue,
//   the kept count and the output valid. No clearing pass is needed.
module similarity_top_k_selector import sstk_pkg::*; #(
   parameter int TOP_K = 64
) (
   input  logic       clock,
   input  logic       reset,
   sstk_req_if.sink   req_if,
   sstk_rsp_if.source rsp_if
);

   logic    push;
   job_type push_data;
   logic    queue_full;
   logic    pop;
   logic    not_empty;
   job_type head;

   sstk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   sstk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   sstk_back #(.TOP_K(TOP_K)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (head),
      .job_pop   (pop),
      .rsp       (rsp_if)
   );

endmodule
